>>> design/fmpd_pkg.sv
package fmpd_pkg;

	// Register file
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_DECIM  = 2'd1;
	localparam logic [1:0] REG_GAIN   = 2'd2;

	localparam int WIN_REG_W  = 7;
	localparam int DEC_REG_W  = 9;
	localparam int GAIN_W     = 16;

	localparam logic [WIN_REG_W-1:0] WIN_RESET  = 7'd32;
	localparam logic [DEC_REG_W-1:0] DEC_RESET  = 9'd16;
	localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd32000;

	// Datapath widths
	localparam int ANGLE_W      = 16;
	localparam int OUT_W        = 32;
	localparam int TURN_W       = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = 4;
	localparam int PRESCALE     = 8;

	typedef struct packed {
		logic [WIN_REG_W-1:0] window_length;
		logic [DEC_REG_W-1:0] decimation_factor;
		logic [GAIN_W-1:0]    rate_gain;
		logic                 window_clear;
	} cfg_t;

	// atan(2^-k) in units of 2^-32 turn
	function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] k);
		logic [TURN_W-1:0] t;
		case (k)
			4'd0:    t = 32'd536870912;
			4'd1:    t = 32'd316933406;
			4'd2:    t = 32'd167458907;
			4'd3:    t = 32'd85004756;
			4'd4:    t = 32'd42667331;
			4'd5:    t = 32'd21354465;
			4'd6:    t = 32'd10679838;
			4'd7:    t = 32'd5340245;
			4'd8:    t = 32'd2670163;
			4'd9:    t = 32'd1335087;
			4'd10:   t = 32'd667544;
			4'd11:   t = 32'd333772;
			4'd12:   t = 32'd166886;
			4'd13:   t = 32'd83443;
			4'd14:   t = 32'd41722;
			default: t = 32'd20861;
		endcase
		return t;
	endfunction

endpackage

>>> design/fmpd_regs.sv
module fmpd_regs
	import fmpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [WIN_REG_W-1:0] window_q;
	logic [DEC_REG_W-1:0] decim_q;
	logic [GAIN_W-1:0]    gain_q;
	logic                 wr_en;
	logic [1:0]           reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
			decim_q  <= DEC_RESET;
			gain_q   <= GAIN_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WINDOW: window_q <= pwdata[WIN_REG_W-1:0];
				REG_DECIM:  decim_q  <= pwdata[DEC_REG_W-1:0];
				REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_WINDOW: prdata = DATA_W'(window_q);
			REG_DECIM:  prdata = DATA_W'(decim_q);
			REG_GAIN:   prdata = DATA_W'(gain_q);
			default:    prdata = '0;
		endcase
	end

	// Restart the filter on every write to the window register
	always_comb begin
		cfg.window_length     = window_q;
		cfg.decimation_factor = decim_q;
		cfg.rate_gain         = gain_q;
		cfg.window_clear      = wr_en && (reg_idx == REG_WINDOW);
	end

endmodule

>>> design/fmpd_cordic.sv
module fmpd_cordic
	import fmpd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] in_phase,
	input  logic signed [SAMPLE_BITS-1:0] quadrature,
	output logic                          done,
	output logic [ANGLE_W-1:0]            angle
);

	// prescaled magnitude plus CORDIC growth and negation headroom
	localparam int XW = SAMPLE_BITS + PRESCALE + 2;

	logic signed [XW-1:0] x_q, y_q;
	logic [TURN_W-1:0]    z_q;
	logic [STEP_W-1:0]    k_q;
	logic                 busy_q, done_q, zero_q;
	logic signed [XW-1:0] xs, ys, dx, dy;

	// Prescale the sample
	assign xs = XW'(in_phase) <<< PRESCALE;
	assign ys = XW'(quadrature) <<< PRESCALE;
	assign dx = y_q >>> k_q;
	assign dy = x_q >>> k_q;

	// Load on start, then one vectoring micro-rotation per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			k_q    <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				zero_q <= (in_phase == '0) && (quadrature == '0);
				if (xs < 0) begin
					x_q <= -xs;
					y_q <= -ys;
					z_q <= 32'h8000_0000;
				end else begin
					x_q <= xs;
					y_q <= ys;
					z_q <= '0;
				end
			end else if (busy_q) begin
				if (y_q >= 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_turn(k_q);
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_turn(k_q);
				end
				k_q <= k_q + 1'b1;
				if (k_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Round the turn count to a 16-bit binary angle
	assign done  = done_q;
	assign angle = zero_q ? '0 : z_q[TURN_W-1:TURN_W-ANGLE_W] + ANGLE_W'(z_q[TURN_W-ANGLE_W-1]);

endmodule

>>> design/fmpd_divider.sv
module fmpd_divider #(
	parameter int N_W = 40,
	parameter int D_W = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	// two restoring steps per cycle
	localparam int DV_W  = N_W + (N_W % 2);
	localparam int STEPS = DV_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DV_W-1:0]  nq_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DV_W-1:0]  nq_n;
	logic [D_W:0]     r_n;

	// Shift in two dividend bits, subtract where the divisor fits
	always_comb begin
		nq_n = nq_q;
		r_n  = {1'b0, rem_q};
		for (int j = 0; j < 2; j++) begin
			r_n  = {r_n[D_W-1:0], nq_n[DV_W-1]};
			nq_n = nq_n << 1;
			if (r_n >= {1'b0, div_q}) begin
				r_n     = r_n - {1'b0, div_q};
				nq_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			nq_q   <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				nq_q   <= DV_W'(dividend);
				rem_q  <= '0;
				div_q  <= divisor;
			end else if (busy_q) begin
				nq_q  <= nq_n;
				rem_q <= r_n[D_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = nq_q[N_W-1:0];

endmodule

>>> design/fm_phase_discriminator.sv
// Channel  Direction  Handshake            Payload
// config   in/out     psel/penable/pready  paddr, pwdata, prdata (APB write/read)
// input    in         in_valid/in_ready    in_phase, quadrature
// output   out        out_valid/out_ready  freq_out
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Angle: 16 CORDIC iterations of one shared rotator, one per cycle.
// An item without result passes rotation and ring update (the first sample rotation only);
// with a result it goes on through multiply, divide and hand-off.
// Reset clears the filter at once: ring entries read as zero until the ring wraps.
// A result waiting on out_ready does not block the next request; a second one stalls.
module fm_phase_discriminator
	import fmpd_pkg::*;
#(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int DECIM_MAX   = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_phase,
	input  logic signed [SAMPLE_BITS-1:0] quadrature,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUT_W-1:0]       freq_out
);

	localparam int RP_W   = $clog2(WINDOW_MAX);
	localparam int WCNT_W = $clog2(WINDOW_MAX + 1);
	localparam int DC_W   = $clog2(DECIM_MAX);
	localparam int DCNT_W = $clog2(DECIM_MAX + 1);
	localparam int SUM_W  = ANGLE_W + 1 + $clog2(WINDOW_MAX);
	localparam int PROD_W = SUM_W + GAIN_W + 1;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_ROT    = 7'b0000010,
		S_UPD    = 7'b0000100,
		S_MUL    = 7'b0001000,
		S_DIV_GO = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	cfg_t                        cfg;
	state_t                      state_q;
	logic                        cor_start, cor_done;
	logic [ANGLE_W-1:0]          cor_angle;
	logic [ANGLE_W-1:0]          prev_q;
	logic                        have_prev_q;
	logic signed [ANGLE_W-1:0]   diff_q;
	logic [RP_W-1:0]             pos_q;
	logic                        wrapped_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic [DC_W-1:0]             dcnt_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [OUT_W-1:0]     freq_q;
	logic                        out_valid_q;
	logic [WCNT_W-1:0]           win_eff;
	logic [DCNT_W-1:0]           dec_eff;
	logic signed [ANGLE_W-1:0]   ring_mem [WINDOW_MAX];
	logic signed [ANGLE_W-1:0]   ring_rd_q;
	logic signed [ANGLE_W-1:0]   old_diff;
	logic [PROD_W-1:0]           mag;
	logic                        div_start, div_done;
	logic [PROD_W-1:0]           quo, quo_neg;
	logic signed [OUT_W-1:0]     sat_val;
	logic                        emit;

	fmpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fmpd_cordic #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cor_start),
		.in_phase   (in_phase),
		.quadrature (quadrature),
		.done       (cor_done),
		.angle      (cor_angle)
	);

	fmpd_divider #(
		.N_W (PROD_W),
		.D_W (WCNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (win_eff),
		.done     (div_done),
		.quotient (quo)
	);

	// Clamp window and decimation settings into range
	always_comb begin
		if (cfg.window_length == '0)
			win_eff = WCNT_W'(1);
		else if (32'(cfg.window_length) > WINDOW_MAX)
			win_eff = WCNT_W'(WINDOW_MAX);
		else
			win_eff = WCNT_W'(cfg.window_length);
		if (cfg.decimation_factor == '0)
			dec_eff = DCNT_W'(1);
		else if (32'(cfg.decimation_factor) > DECIM_MAX)
			dec_eff = DCNT_W'(DECIM_MAX);
		else
			dec_eff = DCNT_W'(cfg.decimation_factor);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cor_start = in_valid && in_ready;
	assign div_start = (state_q == S_DIV_GO);
	assign emit      = (dcnt_q == '0);

	// Entries not yet written since the last clear read as zero
	assign old_diff = wrapped_q ? ring_rd_q : '0;

	// Difference ring
	always_ff @(posedge clk) begin
		if (state_q == S_UPD)
			ring_mem[pos_q] <= diff_q;
		ring_rd_q <= ring_mem[pos_q];
	end

	// Magnitude for the divider, signed saturation of the quotient
	assign mag     = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign quo_neg = ~quo + PROD_W'(1);
	always_comb begin
		if (!prod_q[PROD_W-1]) begin
			if (quo > PROD_W'(64'h7FFF_FFFF))
				sat_val = 32'sh7FFF_FFFF;
			else
				sat_val = OUT_W'(quo);
		end else begin
			if (quo > PROD_W'(64'h8000_0000))
				sat_val = 32'sh8000_0000;
			else
				sat_val = OUT_W'(quo_neg);
		end
	end

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			diff_q      <= '0;
			pos_q       <= '0;
			wrapped_q   <= 1'b0;
			sum_q       <= '0;
			dcnt_q      <= '0;
			prod_q      <= '0;
			freq_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			if (cfg.window_clear) begin
				pos_q     <= '0;
				wrapped_q <= 1'b0;
				sum_q     <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cor_start)
						state_q <= S_ROT;
				end
				S_ROT: begin
					if (cor_done) begin
						prev_q <= cor_angle;
						if (!have_prev_q) begin
							have_prev_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							diff_q  <= $signed(cor_angle - prev_q);
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					sum_q <= sum_q - SUM_W'(old_diff) + SUM_W'(diff_q);
					if (32'(pos_q) + 1 >= 32'(win_eff)) begin
						pos_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
					if (32'(dcnt_q) + 1 >= 32'(dec_eff))
						dcnt_q <= '0;
					else
						dcnt_q <= dcnt_q + 1'b1;
					state_q <= emit ? S_MUL : S_IDLE;
				end
				S_MUL: begin
					prod_q  <= sum_q * $signed({1'b0, cfg.rate_gain});
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						freq_q      <= sat_val;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign freq_out  = freq_q;

`ifndef SYNTHESIS
	a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == S_ROT)
		else $error("angle finished outside rotation state");
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("quotient finished outside divide state");
	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < 32'(win_eff))
		else $error("ring position beyond active window");
	a_accept_starts_rot: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_ROT)
		else $error("accepted request did not start rotation");
`endif

endmodule

>>> sim/fm_phase_discriminator_test.sv
module fm_phase_discriminator_test;
	import fmpd_pkg::*;

	localparam int WIN_LIMIT = 64;
	localparam int DEC_LIMIT = 256;
	localparam int ANGLE_STEPS = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 64;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam real PI = 3.14159265358979;

	// atan(2^-k) in 2^-32 turn
	localparam logic [31:0] ATAN_STEP [ANGLE_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861
	};

	localparam int DIRECTED_N = 20;
	localparam logic signed [15:0] DIR_I [DIRECTED_N] = '{
		16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 16'sd0,
		-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
		-16'sd32768, -16'sd32768, 16'sd0, 16'sd1, -16'sd1,
		-16'sd1, 16'sd1, 16'sd0, -16'sd1, 16'sd1
	};
	localparam logic signed [15:0] DIR_Q [DIRECTED_N] = '{
		16'sd0, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768,
		-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd1,
		-16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0,
		-16'sd1, 16'sd1, 16'sd1, 16'sd1, -16'sd1
	};
	localparam logic signed [15:0] EDGE_VALS [5] = '{
		-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
	};

	// Bit-true discriminator: angle, difference, moving average, decimation, gain scaling, saturation
	class freq_predictor;
		logic [WIN_REG_W-1:0] win_reg;
		logic [DEC_REG_W-1:0] dec_reg;
		logic [GAIN_W-1:0] gain_reg;
		logic [15:0] prev_angle;
		bit have_prev;
		logic signed [15:0] diff_ring [WIN_LIMIT];
		int ring_pos;
		longint running_sum;
		int decim_count;
		logic signed [31:0] freq_expected [$];
		int errors;

		function new();
			win_reg = WIN_RESET;
			dec_reg = DEC_RESET;
			gain_reg = GAIN_RESET;
			prev_angle = '0;
			have_prev = 1'b0;
			decim_count = 0;
			errors = 0;
			clear_filter();
		endfunction

		function void clear_filter();
			foreach (diff_ring[k]) diff_ring[k] = '0;
			ring_pos = 0;
			running_sum = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_WINDOW: begin
					win_reg = val[WIN_REG_W-1:0];
					clear_filter();
				end
				REG_DECIM: dec_reg = val[DEC_REG_W-1:0];
				REG_GAIN: gain_reg = val[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Vectoring CORDIC to a 16-bit binary angle
		function logic [15:0] phase_angle(logic signed [15:0] i_s, logic signed [15:0] q_s);
			longint x, y, dx, dy;
			logic [31:0] z, rounded;
			int k;
			if (i_s == 0 && q_s == 0)
				return '0;
			x = longint'(i_s) * 256;
			y = longint'(q_s) * 256;
			z = '0;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = 32'h8000_0000;
			end
			for (k = 0; k < ANGLE_STEPS; k++) begin
				dx = y >>> k;
				dy = x >>> k;
				if (y >= 0) begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_STEP[k];
				end else begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_STEP[k];
				end
			end
			rounded = z + 32'h0000_8000;
			return rounded[31:16];
		endfunction

		function void note_sample(logic signed [15:0] i_s, logic signed [15:0] q_s);
			logic [15:0] ang, raw;
			logic signed [15:0] diff;
			int win, dec;
			longint prod;
			bit emit;
			ang = phase_angle(i_s, q_s);
			win = (win_reg == 0) ? 1 : (win_reg > WIN_LIMIT) ? WIN_LIMIT : int'(win_reg);
			dec = (dec_reg == 0) ? 1 : (dec_reg > DEC_LIMIT) ? DEC_LIMIT : int'(dec_reg);
			// hold the first angle only
			if (!have_prev) begin
				prev_angle = ang;
				have_prev = 1'b1;
				return;
			end
			raw = ang - prev_angle;
			diff = raw;
			prev_angle = ang;
			// advance the moving-average ring
			if (ring_pos >= win)
				ring_pos = 0;
			running_sum = running_sum - diff_ring[ring_pos];
			diff_ring[ring_pos] = diff;
			running_sum = running_sum + diff;
			ring_pos++;
			if (ring_pos >= win)
				ring_pos = 0;
			// drop all but one of every dec values
			emit = (decim_count == 0);
			if (decim_count + 1 >= dec)
				decim_count = 0;
			else
				decim_count++;
			if (!emit)
				return;
			prod = (running_sum * longint'(gain_reg)) / longint'(win);
			if (prod > 64'sd2147483647)
				prod = 64'sd2147483647;
			if (prod < -64'sd2147483648)
				prod = -64'sd2147483648;
			freq_expected.push_back(prod[31:0]);
		endfunction

		function void check_freq(logic signed [31:0] got);
			logic signed [31:0] want;
			if (freq_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected freq_out %0d", $time, got);
				return;
			end
			want = freq_expected.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: freq_out mismatch, expected %0d, got %0d", $time, want, got);
			end
		endfunction

		function int pending();
			return freq_expected.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] in_phase;
	logic signed [15:0] quadrature;
	logic out_valid;
	logic out_ready;
	logic signed [OUT_W-1:0] freq_out;

	freq_predictor freq_model = new();
	int tx_idle_pct = 23;
	int rx_idle_pct = 45;
	int stall_cycles = 0;

	fm_phase_discriminator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_phase   (in_phase),
		.quadrature (quadrature),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.freq_out   (freq_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check each result request and stall the receiver at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			freq_model.check_freq(freq_out);
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("fm_phase_discriminator_test: errors");
			$finish;
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		freq_model.write_reg(idx, val);
	endtask

	task automatic set_config(input logic [31:0] win, input logic [31:0] dec,
			input logic [31:0] gain);
		apb_write(REG_WINDOW, win);
		apb_write(REG_DECIM, dec);
		apb_write(REG_GAIN, gain);
	endtask

	// Drain all results, then let a result-free request finish
	task automatic settle();
		in_valid <= 1'b0;
		while (freq_model.pending() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_sample(input logic signed [15:0] i_s, input logic signed [15:0] q_s);
		// idle the sender for a random stretch
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(30, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_phase <= i_s;
		quadrature <= q_s;
		do @(posedge clk); while (!in_ready);
		freq_model.note_sample(i_s, q_s);
	endtask

	task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
			input bit hold_mid);
		logic signed [15:0] i_s, q_s;
		int n, kind, amp;
		real ph, step;
		ph = 0.0;
		step = 0.3;
		amp = 20000;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (n = 0; n < n_items; n++) begin
			// hold off new requests until every result is back
			if (hold_mid && n == n_items / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (freq_model.pending() > 0) @(posedge clk);
			end
			kind = $urandom_range(99);
			if (kind < 50) begin
				// rotating phasor, retuned now and then
				if ($urandom_range(31) == 0) begin
					step = (real'($urandom_range(4000)) - 2000.0) * PI / 2000.0;
					amp = $urandom_range(32767, 1);
				end
				ph = ph + step;
				if (ph > PI)
					ph = ph - 2.0 * PI;
				if (ph < -PI)
					ph = ph + 2.0 * PI;
				i_s = 16'($rtoi(amp * $cos(ph)));
				q_s = 16'($rtoi(amp * $sin(ph)));
			end else if (kind < 80) begin
				i_s = 16'($urandom);
				q_s = 16'($urandom);
			end else if (kind < 90) begin
				i_s = 16'($urandom_range(8));
				i_s = i_s - 16'sd4;
				q_s = 16'($urandom_range(8));
				q_s = q_s - 16'sd4;
			end else begin
				i_s = EDGE_VALS[$urandom_range(4)];
				q_s = EDGE_VALS[$urandom_range(4)];
			end
			send_sample(i_s, q_s);
		end
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_phase = '0;
		quadrature = '0;
		out_ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: masked window write, unused address, axis and corner vectors
		set_config(32'hFFFF_FF84, 32'd1, 32'd65535);
		apb_write(REG_UNUSED, 32'h0000_005A);
		for (n = 0; n < DIRECTED_N; n++)
			send_sample(DIR_I[n], DIR_Q[n]);
		settle();

		set_config(32'd1, 32'd1, 32'd65535);
		run_phase(300, 23, 45, 1'b0);
		settle();
		set_config(32'd64, 32'd3, 32'd1);
		run_phase(300, 23, 45, 1'b0);
		settle();
		set_config(32'd0, 32'd0, 32'd0);
		run_phase(150, 45, 23, 1'b0);
		settle();
		set_config(32'd127, 32'd511, 32'd40000);
		run_phase(300, 45, 23, 1'b0);
		settle();
		// lower the factor below the running count
		set_config($urandom_range(63, 2), 32'd5, $urandom_range(65535, 1));
		run_phase(400, 0, 0, 1'b1);
		settle();
		set_config(32'd32, 32'd16, 32'd32000);
		run_phase(350, 0, 0, 1'b0);
		settle();

		if (freq_model.errors == 0 && freq_model.pending() == 0)
			$display("fm_phase_discriminator_test: clean");
		else
			$display("fm_phase_discriminator_test: errors");
		$finish;
	end

endmodule
